FILE: hw/rtl/spt_pkg.sv
// Shared types and constants for the similarity peak tachometer.
package spt_pkg;

   // Fixed field widths.
   localparam int unsigned THRESH_W = 16;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned RPM_W    = 26;
   localparam int unsigned SEEN_W   = 3;

   // Threshold after reset: 0.2 in Q0.16.
   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd13107;

   // Microseconds in one minute, the dividend of the rpm calculation.
   localparam logic [RPM_W-1:0] RPM_NUMERATOR = 26'd60000000;

   // Sample counter saturates at a full window of four samples.
   localparam logic [SEEN_W-1:0] SEEN_MAX   = 3'd4;
   // Samples seen before the current one for the window to be full.
   localparam logic [SEEN_W-1:0] SEEN_PRIOR = 3'd3;

   // One quotient bit per divider step.
   localparam int unsigned DIV_STEPS = RPM_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // capture an input transaction
      logic csr_write;  // write the peak threshold
      logic div_init;   // load the divider
      logic div_step;   // one restoring division step
      logic load_out;   // move the result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;   // peak found with a non-zero period
   } status_type;

endpackage

FILE: hw/rtl/similarity_peak_tachometer.sv
// Top level of the similarity peak tachometer.
//
// Takes one similarity sample with a microsecond timestamp per transaction and returns one
// result per transaction. A revolution is flagged when the previous sample is strictly above
// the threshold, the newest sample and the two samples before it, once four samples have been
// seen; rpm is then 60000000 divided by the time since the last peak (modulo 2^32), saturating
// at 60000000 for a zero period, and rpm and period read zero when no revolution is flagged.
// One transaction is processed at a time. A transaction without a division passes through the
// evaluate and load states before the next one is accepted; a peak with a non-zero period also
// passes the one-bit-per-cycle restoring divider before the load. The output register lets the
// next transaction be accepted while a result still waits to be taken. The threshold register
// may be written when no transaction is in flight.
module similarity_peak_tachometer #(
   parameter int unsigned SAMPLE_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [SAMPLE_WIDTH-1:0]            req_similarity,
   input  logic [spt_pkg::TIME_W-1:0]         req_time_us,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_revolution,
   output logic [spt_pkg::RPM_W-1:0]          rsp_rpm,
   output logic [spt_pkg::TIME_W-1:0]         rsp_period_us,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [spt_pkg::THRESH_W-1:0]       csr_peak_threshold
);

   spt_pkg::cmd_type    cmd;
   spt_pkg::status_type status;

   // Controller.
   spt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath.
   spt_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_similarity     (req_similarity),
      .req_time_us        (req_time_us),
      .csr_peak_threshold (csr_peak_threshold),
      .rsp_revolution     (rsp_revolution),
      .rsp_rpm            (rsp_rpm),
      .rsp_period_us      (rsp_period_us)
   );

`ifndef NO_ASSERTIONS
   // A result without a revolution carries zero rpm and zero period.
   a_no_rev_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_revolution) |-> (rsp_rpm == '0 && rsp_period_us == '0))
      else $error("result without revolution has non-zero rpm or period");

   // The rpm never exceeds one revolution per microsecond.
   a_rpm_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rpm <= spt_pkg::RPM_NUMERATOR))
      else $error("rpm above saturation value");

   // A period of one microsecond or zero gives the saturated rpm.
   a_rpm_short : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_revolution && rsp_period_us <= 32'd1)
         |-> (rsp_rpm == spt_pkg::RPM_NUMERATOR))
      else $error("short period does not give saturated rpm");

   // The block works on one transaction at a time.
   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while a transaction is in flight");
`endif

endmodule

FILE: hw/rtl/spt_ctrl.sv
// Controller state machine of the similarity peak tachometer.
module spt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                csr_valid,
   output logic                csr_ready,
   output spt_pkg::cmd_type    cmd,
   input  spt_pkg::status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_LOAD
   } state_type;

   state_type                        state_ff, state_in;
   logic [spt_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             out_free;

   // Handshake outputs.
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Next state, step counter and datapath commands.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd.accept    = 1'b0;
      cmd.csr_write = csr_valid && (state_ff == ST_IDLE);
      cmd.div_init  = 1'b0;
      cmd.div_step  = 1'b0;
      cmd.load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.need_div) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == spt_pkg::DIV_CNT_W'(spt_pkg::DIV_STEPS - 1)) begin
               state_in = ST_LOAD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register valid: set on load, cleared when the transaction is taken.
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/spt_datapath.sv
// Datapath of the similarity peak tachometer: sample window, peak test, divider, output register.
module spt_datapath #(
   parameter int unsigned SAMPLE_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  spt_pkg::cmd_type                   cmd,
   output spt_pkg::status_type                status,
   input  logic [SAMPLE_WIDTH-1:0]            req_similarity,
   input  logic [spt_pkg::TIME_W-1:0]         req_time_us,
   input  logic [spt_pkg::THRESH_W-1:0]       csr_peak_threshold,
   output logic                               rsp_revolution,
   output logic [spt_pkg::RPM_W-1:0]          rsp_rpm,
   output logic [spt_pkg::TIME_W-1:0]         rsp_period_us
);

   localparam int unsigned CMP_W =
      (SAMPLE_WIDTH > spt_pkg::THRESH_W) ? SAMPLE_WIDTH : spt_pkg::THRESH_W;

   logic [spt_pkg::THRESH_W-1:0] thr_ff, thr_in;
   logic [SAMPLE_WIDTH-1:0]      prev1_ff, prev1_in;
   logic [SAMPLE_WIDTH-1:0]      prev2_ff, prev2_in;
   logic [SAMPLE_WIDTH-1:0]      prev3_ff, prev3_in;
   logic [spt_pkg::SEEN_W-1:0]   seen_ff, seen_in;
   logic [spt_pkg::TIME_W-1:0]   last_peak_ff, last_peak_in;
   logic                         peak_ff, peak_in;
   logic [spt_pkg::TIME_W-1:0]   period_ff, period_in;
   logic [spt_pkg::TIME_W-1:0]   rem_ff, rem_in;
   logic [spt_pkg::RPM_W-1:0]    quot_ff, quot_in;
   logic                         out_rev_ff, out_rev_in;
   logic [spt_pkg::RPM_W-1:0]    out_rpm_ff, out_rpm_in;
   logic [spt_pkg::TIME_W-1:0]   out_period_ff, out_period_in;

   logic [CMP_W-1:0]             cand_x, thr_x;
   logic                         peak_now;
   logic [spt_pkg::TIME_W-1:0]   period_now;
   logic [spt_pkg::TIME_W:0]     trial, divisor_x, diff;
   logic                         ge;

   // Peak test on the incoming transaction: the previous sample must beat
   // the threshold and its three neighbours, with a full window.
   always_comb begin
      cand_x     = CMP_W'(prev1_ff);
      thr_x      = CMP_W'(thr_ff);
      peak_now   = (seen_ff >= spt_pkg::SEEN_PRIOR) && (cand_x > thr_x) &&
                   (prev1_ff > req_similarity) && (prev1_ff > prev2_ff) &&
                   (prev1_ff > prev3_ff);
      period_now = req_time_us - last_peak_ff;
   end

   // Window, sample count, threshold and last peak time.
   always_comb begin
      thr_in       = cmd.csr_write ? csr_peak_threshold : thr_ff;
      prev1_in     = prev1_ff;
      prev2_in     = prev2_ff;
      prev3_in     = prev3_ff;
      seen_in      = seen_ff;
      last_peak_in = last_peak_ff;
      peak_in      = peak_ff;
      period_in    = period_ff;
      if (cmd.accept) begin
         prev1_in  = req_similarity;
         prev2_in  = prev1_ff;
         prev3_in  = prev2_ff;
         peak_in   = peak_now;
         period_in = peak_now ? period_now : '0;
         if (seen_ff != spt_pkg::SEEN_MAX) begin
            seen_in = seen_ff + 1'b1;
         end
         if (peak_now) begin
            last_peak_in = req_time_us;
         end
      end
   end

   // A division is only needed for a peak with a non-zero period.
   assign status.need_div = peak_ff && (period_ff != '0);

   // Restoring divider: one quotient bit per step, dividend shifted out of quot.
   always_comb begin
      trial     = {rem_ff, quot_ff[spt_pkg::RPM_W-1]};
      divisor_x = {1'b0, period_ff};
      ge        = (trial >= divisor_x);
      diff      = trial - divisor_x;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      if (cmd.div_init) begin
         rem_in  = '0;
         quot_in = spt_pkg::RPM_NUMERATOR;
      end else if (cmd.div_step) begin
         rem_in  = ge ? diff[spt_pkg::TIME_W-1:0] : trial[spt_pkg::TIME_W-1:0];
         quot_in = {quot_ff[spt_pkg::RPM_W-2:0], ge};
      end
   end

   // Output register contents; a zero period saturates the rpm.
   always_comb begin
      out_rev_in    = out_rev_ff;
      out_rpm_in    = out_rpm_ff;
      out_period_in = out_period_ff;
      if (cmd.load_out) begin
         out_rev_in    = peak_ff;
         out_period_in = period_ff;
         if (!peak_ff) begin
            out_rpm_in = '0;
         end else if (period_ff == '0) begin
            out_rpm_in = spt_pkg::RPM_NUMERATOR;
         end else begin
            out_rpm_in = quot_ff;
         end
      end
   end

   // Architectural state; reset clears it, except the threshold, which resets to THRESH_RESET.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= spt_pkg::THRESH_RESET;
         prev1_ff     <= '0;
         prev2_ff     <= '0;
         prev3_ff     <= '0;
         seen_ff      <= '0;
         last_peak_ff <= '0;
         peak_ff      <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         prev1_ff     <= prev1_in;
         prev2_ff     <= prev2_in;
         prev3_ff     <= prev3_in;
         seen_ff      <= seen_in;
         last_peak_ff <= last_peak_in;
         peak_ff      <= peak_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      period_ff     <= period_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      out_rev_ff    <= out_rev_in;
      out_rpm_ff    <= out_rpm_in;
      out_period_ff <= out_period_in;
   end

   assign rsp_revolution = out_rev_ff;
   assign rsp_rpm        = out_rpm_ff;
   assign rsp_period_us  = out_period_ff;

endmodule

FILE: test/similarity_peak_tachometer_tb.sv
// Self-checking testbench for the similarity peak tachometer: peaks, periods and rpm.
module similarity_peak_tachometer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SAMPLE_W     = 16;
   // Margin waited on top of the longest processing time.
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned CYCLE_LIMIT  = 1000000;

   // One result transaction as the block should return it.
   typedef struct packed {
      logic                       revolution;
      logic [spt_pkg::RPM_W-1:0]  rpm;
      logic [spt_pkg::TIME_W-1:0] period_us;
   } tach_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [SAMPLE_W-1:0]          req_similarity = '0;
   logic [spt_pkg::TIME_W-1:0]   req_time_us = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_revolution;
   logic [spt_pkg::RPM_W-1:0]    rsp_rpm;
   logic [spt_pkg::TIME_W-1:0]   rsp_period_us;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [spt_pkg::THRESH_W-1:0] csr_peak_threshold = '0;

   // Predictor state, updated only by the scoreboard process.
   logic [spt_pkg::THRESH_W-1:0] threshold_model = spt_pkg::THRESH_RESET;
   logic [SAMPLE_W-1:0]          sample_back_1 = '0;
   logic [SAMPLE_W-1:0]          sample_back_2 = '0;
   logic [SAMPLE_W-1:0]          sample_back_3 = '0;
   logic [spt_pkg::SEEN_W-1:0]   window_fill = '0;
   logic [spt_pkg::TIME_W-1:0]   last_peak_stamp = '0;

   tach_result_type     expected_results[$];
   int unsigned         mismatch_count = 0;
   int unsigned         cycle_count = 0;

   // Stimulus state.
   logic                         idle_on = 1'b1;
   logic [spt_pkg::THRESH_W-1:0] threshold_now = spt_pkg::THRESH_RESET;
   logic [spt_pkg::TIME_W-1:0]   stamp_now = '0;
   logic                         stall_burst = 1'b0;
   int unsigned                  stall_left = 0;
   logic                         hold_active = 1'b0;
   event                         hold_off_start;

   similarity_peak_tachometer #(
      .SAMPLE_WIDTH(SAMPLE_W)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_similarity     (req_similarity),
      .req_time_us        (req_time_us),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_revolution     (rsp_revolution),
      .rsp_rpm            (rsp_rpm),
      .rsp_period_us      (rsp_period_us),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_peak_threshold (csr_peak_threshold)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Works out the result of one accepted sample and advances the window.
   function automatic tach_result_type predict_revolution(
         input logic [SAMPLE_W-1:0] sample,
         input logic [spt_pkg::TIME_W-1:0] stamp);
      tach_result_type            res;
      logic                       peak;
      logic [spt_pkg::TIME_W-1:0] quotient;
      res = '0;
      peak = (window_fill >= spt_pkg::SEEN_PRIOR) && (sample_back_1 > threshold_model) &&
             (sample_back_1 > sample) && (sample_back_1 > sample_back_2) &&
             (sample_back_1 > sample_back_3);
      if (peak) begin
         res.revolution = 1'b1;
         res.period_us  = stamp - last_peak_stamp;
         quotient       = spt_pkg::RPM_NUMERATOR / res.period_us;
         // A zero period saturates rather than dividing.
         res.rpm        = (res.period_us == '0) ? spt_pkg::RPM_NUMERATOR :
                          quotient[spt_pkg::RPM_W-1:0];
         last_peak_stamp = stamp;
      end
      sample_back_3 = sample_back_2;
      sample_back_2 = sample_back_1;
      sample_back_1 = sample;
      if (window_fill < spt_pkg::SEEN_MAX) begin
         window_fill = window_fill + 1'b1;
      end
      return res;
   endfunction

   // Scoreboard: checks each result transaction, then records register writes and new samples.
   always @(posedge clock) begin
      tach_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with nothing expected: revolution %0d rpm %0d period %0d",
                        $time, rsp_revolution, rsp_rpm, rsp_period_us);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_revolution !== want.revolution) begin
                  $display("%0t: revolution expected %0d, actual %0d",
                           $time, want.revolution, rsp_revolution);
                  mismatch_count++;
               end
               if (rsp_rpm !== want.rpm) begin
                  $display("%0t: rpm expected %0d, actual %0d", $time, want.rpm, rsp_rpm);
                  mismatch_count++;
               end
               if (rsp_period_us !== want.period_us) begin
                  $display("%0t: period_us expected %0d, actual %0d",
                           $time, want.period_us, rsp_period_us);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            threshold_model = csr_peak_threshold;
         end
         if (req_valid && !req_stall) begin
            expected_results = {expected_results,
                                predict_revolution(req_similarity, req_time_us)};
         end
      end
   end

   // Receiver stalls in random bursts, mixed with free-running stretches.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_burst <= idle_on && ($urandom_range(0, 2) == 0);
         stall_left  <= $urandom_range(0, 13);
      end
      rsp_stall <= hold_active || stall_burst;
   end

   // Long receiver hold-off so that the block fills up and stalls its input.
   always begin
      @(hold_off_start);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
         $display("similarity_peak_tachometer_tb: errors");
         $finish;
      end
   end

   // Offers one sample transaction and returns at the edge where it is accepted.
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample,
                              input logic [spt_pkg::TIME_W-1:0] stamp);
      if (idle_on && ($urandom_range(0, 3) == 0)) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_similarity <= sample;
      req_time_us    <= stamp;
      do @(posedge clock); while (req_stall);
   endtask

   // Advances the timestamp by a random step, sometimes zero or a wrapping jump.
   task automatic send_next(input logic [SAMPLE_W-1:0] sample);
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         stamp_now = stamp_now;
      end else if (pick == 1) begin
         stamp_now = stamp_now + $urandom;
      end else if (pick < 4) begin
         stamp_now = stamp_now + $urandom_range(1, 20);
      end else begin
         stamp_now = stamp_now + $urandom_range(1, 60000);
      end
      send_sample(sample, stamp_now);
   endtask

   // Lowers valid and waits until every expected result has come back, plus the pipeline tail.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the peak threshold while the block is idle.
   task automatic write_threshold(input logic [spt_pkg::THRESH_W-1:0] value);
      wait_until_drained();
      csr_valid          <= 1'b1;
      csr_peak_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      threshold_now  = value;
   endtask

   // Mostly well-formed bumps (low, low, crest, low) with random content, the rest noise.
   task automatic send_random_samples(input int unsigned count);
      int unsigned     sent;
      int unsigned     run;
      logic [SAMPLE_W-1:0] crest;
      logic [SAMPLE_W-1:0] level;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 7) begin
            crest = ($urandom_range(0, 9) == 0) ? SAMPLE_W'($urandom) :
                    SAMPLE_W'($urandom_range(threshold_now, 65535));
            send_next(SAMPLE_W'($urandom_range(0, crest)));
            send_next(SAMPLE_W'($urandom_range(0, crest)));
            send_next(crest);
            send_next(SAMPLE_W'($urandom_range(0, crest)));
            sent += 4;
         end else begin
            // Noise, with repeated levels to form plateaus.
            run   = $urandom_range(1, 4);
            level = SAMPLE_W'($urandom);
            repeat (run) send_next(($urandom_range(0, 1) == 0) ? level : SAMPLE_W'($urandom));
            sent += run;
         end
      end
   endtask

   // Hand-picked sequence at the reset threshold covering the corner cases.
   task automatic test_directed_cases();
      // No peak before the window holds four samples.
      send_sample(16'hFFFF, 32'd16);
      send_sample(16'h0000, 32'd20);
      send_sample(16'h0000, 32'd30);
      send_sample(16'h0000, 32'd40);
      // First peak, measured from time zero.
      send_sample(16'd40000, 32'd1000);
      send_sample(16'h0000, 32'd1000000);
      send_sample(16'h0000, 32'd1000010);
      // A sample equal to the threshold is no peak.
      send_sample(spt_pkg::THRESH_RESET, 32'd1000020);
      send_sample(16'h0000, 32'd1000030);
      // Peak at the same timestamp as the last one: zero period.
      send_sample(spt_pkg::THRESH_RESET + 1'b1, 32'd1000000);
      send_sample(16'h0000, 32'd1000000);
      // Plateau: equal neighbours give no peak.
      send_sample(16'd50000, 32'd1000100);
      send_sample(16'd50000, 32'd1000200);
      send_sample(16'h0000, 32'd1000300);
      // Timestamp one behind the last peak: longest period, rpm of zero.
      send_sample(16'hFFFF, 32'd999999);
      send_sample(16'h0000, 32'd999999);
      send_sample(16'h0001, 32'hFFFF_FFFF);
      send_sample(16'h0002, 32'h0000_0000);
      send_sample(16'hFFFE, 32'h0000_0000);
      send_sample(16'h0000, 32'hFFFF_FFFF);
      // Period of one across the timestamp wrap.
      send_sample(16'h0000, 32'h0000_0005);
      send_sample(16'h0000, 32'h7FFF_FFFF);
      send_sample(16'd60000, 32'hFFFF_FFFF);
      send_sample(16'h0000, 32'h0000_0000);
   endtask

   // Threshold at both ends of its range, then back to the reset value.
   task automatic test_threshold_extremes();
      write_threshold(16'h0000);
      send_random_samples(60);
      write_threshold(16'hFFFF);
      send_random_samples(60);
      write_threshold(spt_pkg::THRESH_RESET);
      send_random_samples(20);
   endtask

   // Receiver holds off for a long stretch while samples keep arriving back to back.
   task automatic test_output_hold();
      idle_on <= 1'b0;
      -> hold_off_start;
      send_random_samples(40);
      idle_on <= 1'b1;
   endtask

   // Long random run in phases, each with its own threshold and idling mode.
   task automatic test_random_peaks();
      int unsigned phase;
      for (phase = 0; phase < 4; phase++) begin
         write_threshold(spt_pkg::THRESH_W'($urandom_range(0, 40000)));
         idle_on <= (phase == 0) || ($urandom_range(0, 3) != 0);
         send_random_samples(250);
      end
   endtask

   // Closing stretch at full rate on both sides.
   task automatic test_full_rate_tail();
      write_threshold(spt_pkg::THRESH_W'($urandom_range(0, 30000)));
      idle_on <= 1'b0;
      send_random_samples(100);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_threshold_extremes();
      test_output_hold();
      test_random_peaks();
      test_full_rate_tail();
      wait_until_drained();
      if (mismatch_count == 0) begin
         $display("similarity_peak_tachometer_tb: clean");
      end else begin
         $display("similarity_peak_tachometer_tb: errors");
      end
      $finish;
   end

endmodule
